// ===== src/jmfe_pkg.sv =====
// Package for the JSON message field extractor: phase codes, result kinds,
// size limits and key-name lookup functions. No dependencies.
`default_nettype none
package jmfe_pkg;

    localparam int ValueMax   = 63;
    localparam int PayloadMax = 1023;
    localparam int LenW       = 10;

    localparam logic [4:0] PH_START      = 5'd0;
    localparam logic [4:0] PH_TOP_MEMBER = 5'd1;
    localparam logic [4:0] PH_TOP_KEY    = 5'd2;
    localparam logic [4:0] PH_TOP_COLON  = 5'd3;
    localparam logic [4:0] PH_TOP_VALUE  = 5'd4;
    localparam logic [4:0] PH_BODY       = 5'd5;
    localparam logic [4:0] PH_TOP_AFTER  = 5'd6;
    localparam logic [4:0] PH_HDR_MEMBER = 5'd7;
    localparam logic [4:0] PH_HDR_KEY    = 5'd8;
    localparam logic [4:0] PH_HDR_COLON  = 5'd9;
    localparam logic [4:0] PH_HDR_VALUE  = 5'd10;
    localparam logic [4:0] PH_HOST       = 5'd11;
    localparam logic [4:0] PH_OTHER      = 5'd12;
    localparam logic [4:0] PH_XFF        = 5'd13;
    localparam logic [4:0] PH_XFF_REST   = 5'd14;
    localparam logic [4:0] PH_HDR_AFTER  = 5'd15;

    localparam logic [2:0] K_ROUTE_CLR = 3'd0;
    localparam logic [2:0] K_ROUTE     = 3'd1;
    localparam logic [2:0] K_PAY_CLR   = 3'd2;
    localparam logic [2:0] K_PAY       = 3'd3;
    localparam logic [2:0] K_OK        = 3'd4;
    localparam logic [2:0] K_ERR       = 3'd5;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_A    = 2'd1;
    localparam logic [1:0] TGT_B    = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
    } t_result;

    function automatic logic [7:0] name_headers(input logic [4:0] p);
        unique case (p)
            5'd0: name_headers = "h";
            5'd1: name_headers = "e";
            5'd2: name_headers = "a";
            5'd3: name_headers = "d";
            5'd4: name_headers = "e";
            5'd5: name_headers = "r";
            5'd6: name_headers = "s";
            default: name_headers = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] name_body(input logic [4:0] p);
        unique case (p)
            5'd0: name_body = "b";
            5'd1: name_body = "o";
            5'd2: name_body = "d";
            5'd3: name_body = "y";
            default: name_body = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] name_host(input logic [4:0] p);
        unique case (p)
            5'd0: name_host = "H";
            5'd1: name_host = "o";
            5'd2: name_host = "s";
            5'd3: name_host = "t";
            default: name_host = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] name_xff(input logic [4:0] p);
        unique case (p)
            5'd0:  name_xff = "X";
            5'd1:  name_xff = "-";
            5'd2:  name_xff = "F";
            5'd3:  name_xff = "o";
            5'd4:  name_xff = "r";
            5'd5:  name_xff = "w";
            5'd6:  name_xff = "a";
            5'd7:  name_xff = "r";
            5'd8:  name_xff = "d";
            5'd9:  name_xff = "e";
            5'd10: name_xff = "d";
            5'd11: name_xff = "-";
            5'd12: name_xff = "F";
            5'd13: name_xff = "o";
            5'd14: name_xff = "r";
            default: name_xff = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== src/jmfe_addr.sv =====
// Dotted-quad address accumulator for the forwarded-for item.
// Depends on jmfe_pkg.
`default_nettype none
module jmfe_addr
    import jmfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,   // restart address
    input  wire logic        i_commit,  // close current group
    input  wire logic        i_char,    // feed one character
    input  wire logic [7:0]  i_c,
    output logic [31:0]      o_addr
);
    logic [9:0]  r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_idx, n_idx;
    logic        r_stop, n_stop;
    logic [31:0] r_addr, n_addr;
    logic [4:0]  shamt;
    logic        do_commit;
    logic        feed;

    assign o_addr = r_addr;

    always_comb begin
        n_acc = r_acc; n_cnt = r_cnt; n_idx = r_idx; n_stop = r_stop; n_addr = r_addr;
        do_commit = 1'b0;
        feed = 1'b0;
        if (i_clear) begin
            n_acc = '0; n_cnt = '0; n_idx = '0; n_stop = 1'b0; n_addr = '0;
        end else if (i_commit) begin
            do_commit = 1'b1;
        end else if (i_char && r_idx < 3'd4) begin
            if (i_c == ".") begin
                do_commit = 1'b1;
            end else if (r_cnt == 2'd3) begin
                do_commit = 1'b1;
                feed = (r_idx != 3'd3);
            end else begin
                feed = 1'b1;
            end
        end
        shamt = 5'(5'd24 - {r_idx[1:0], 3'b000});
        if (do_commit) begin
            if (r_idx < 3'd4) begin
                n_addr = r_addr | (32'(r_acc) << shamt);
                n_idx  = r_idx + 3'd1;
            end
            n_acc = '0; n_cnt = '0; n_stop = 1'b0;
        end
        if (feed) begin
            if (!(do_commit ? 1'b0 : r_stop) && i_c >= "0" && i_c <= "9") begin
                n_acc = 10'((do_commit ? 10'd0 : r_acc) * 10'd10 + 10'(i_c - "0"));
            end else begin
                n_stop = 1'b1;
            end
            n_cnt = (do_commit ? 2'd0 : r_cnt) + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0; r_cnt <= '0; r_idx <= '0; r_stop <= 1'b0; r_addr <= '0;
        end else begin
            r_acc <= n_acc; r_cnt <= n_cnt; r_idx <= n_idx; r_stop <= n_stop;
            r_addr <= n_addr;
        end
    end
endmodule
`default_nettype wire

// ===== src/json_message_field_extractor.sv =====
// JSON message field extractor: one message byte in per transaction, at most
// one result transaction out.
//
// Input channel: i_valid / o_stall with i_msg_byte and i_start_of_message.
// i_start_of_message restarts the parse before its byte is taken.
// Output channel: o_valid / i_stall with o_kind, o_data_byte and
// o_client_address. Kinds: route clear, route byte, payload clear, payload
// byte, message ok (with the address), message error.
//
// Throughput: one byte per cycle while o_stall is low. All parse work for a
// byte is done in the cycle it is accepted; its result is registered in the
// output register, or in the single skid entry while the output is held, so
// a byte is still taken in the cycle the receiver raises stall; o_stall
// rises only once the skid entry holds a result.
// Reset (synchronous, active low) returns the parser to waiting for the
// opening brace and empties both output registers.
// After message ok or error, bytes are consumed without result until the
// next start of message. Route bytes are capped at 63, payload at 1023.
`default_nettype none
module json_message_field_extractor
    import jmfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_start_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [31:0]      o_client_address
);
    logic        take;
    t_result     res;
    logic        a_clear, a_commit, a_char;
    logic [31:0] addr;

    // Output register plus skid entry.
    logic        r_ov, r_sv;
    logic [2:0]  r_ok, r_sk;
    logic [7:0]  r_od, r_sd;
    logic [31:0] r_oa, r_sa;
    logic        res_ok;

    assign o_stall = r_sv;
    assign take    = i_valid && !r_sv;

    jmfe_parse u_parse (
        .i_clk, .i_rst_n, .i_take(take), .i_c(i_msg_byte), .i_som(i_start_of_message),
        .o_res(res), .o_a_clear(a_clear), .o_a_commit(a_commit), .o_a_char(a_char),
        .o_ok(res_ok)
    );

    jmfe_addr u_addr (
        .i_clk, .i_rst_n, .i_clear(a_clear), .i_commit(a_commit), .i_char(a_char),
        .i_c(i_msg_byte), .o_addr(addr)
    );

    // The address register is only updated by XFF bytes and start of message, never
    // on the ok byte, so its current value is the one to report.
    logic [31:0] res_addr;
    assign res_addr = res_ok ? addr : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || !i_stall) begin
                // Output free: advance skid, else new result.
                if (r_sv) begin
                    r_ov <= 1'b1; r_ok <= r_sk; r_od <= r_sd; r_oa <= r_sa;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= take && res.valid;
                    r_ok <= res.kind; r_od <= res.data; r_oa <= res_addr;
                end
            end else if (take && res.valid) begin
                // Output held: park in skid.
                r_sv <= 1'b1;
                r_sk <= res.kind; r_sd <= res.data; r_sa <= res_addr;
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_ok;
    assign o_data_byte      = r_od;
    assign o_client_address = r_oa;
endmodule
`default_nettype wire

// ===== src/jmfe_parse.sv =====
// Byte-level parse sequencer: phase, key matching and value lengths.
// Depends on jmfe_pkg.
`default_nettype none
module jmfe_parse
    import jmfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_c,
    input  wire logic        i_som,
    output t_result          o_res,
    output logic             o_a_clear,
    output logic             o_a_commit,
    output logic             o_a_char,
    output logic             o_ok
);
    logic [4:0]      r_ph, n_ph, ph;
    logic [4:0]      r_kp, n_kp, kp;
    logic [1:0]      r_ka, n_ka, ka;
    logic [1:0]      r_tg, n_tg, tg;
    logic [LenW-1:0] r_len, n_len, len;
    logic            r_fin, n_fin, fin;
    logic            is_hdr_key;
    logic [7:0]      na, nb;
    logic [4:0]      la, lb;

    always_comb begin
        // Restart before the byte is taken.
        ph  = i_som ? PH_START : r_ph;
        kp  = i_som ? 5'd0 : r_kp;
        ka  = i_som ? 2'd3 : r_ka;
        tg  = i_som ? TGT_NONE : r_tg;
        len = i_som ? '0 : r_len;
        fin = i_som ? 1'b0 : r_fin;
        n_ph = ph; n_kp = kp; n_ka = ka; n_tg = tg; n_len = len; n_fin = fin;
        o_res = '0;
        o_a_clear  = i_som;
        o_a_commit = 1'b0;
        o_a_char   = 1'b0;
        o_ok       = 1'b0;
        is_hdr_key = (ph == PH_HDR_KEY);
        na = is_hdr_key ? name_host(kp) : name_headers(kp);
        nb = is_hdr_key ? name_xff(kp)  : name_body(kp);
        la = is_hdr_key ? 5'd4  : 5'd7;
        lb = is_hdr_key ? 5'd15 : 5'd4;
        if (fin) begin
            // Drop bytes until next message.
        end else if (i_c == 8'd0) begin
            n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0};
        end else begin
            unique case (ph)
                PH_START: begin
                    if (i_c == "{") n_ph = PH_TOP_MEMBER;
                    else if (i_c != " ") begin n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0}; end
                end
                PH_TOP_MEMBER, PH_TOP_AFTER: begin
                    if (ph == PH_TOP_AFTER) n_ph = PH_TOP_MEMBER;
                    if (ph == PH_TOP_AFTER && i_c == ",") begin
                    end else if (i_c == " ") begin
                    end else if (i_c == "}") begin
                        n_fin = 1'b1; o_ok = 1'b1; o_res = '{1'b1, K_OK, 8'd0};
                    end else begin
                        n_kp = '0; n_ka = 2'd3; n_ph = PH_TOP_KEY;
                    end
                end
                PH_TOP_KEY, PH_HDR_KEY: begin
                    if (i_c == "\"") begin
                        if (ka[0] && kp == la) n_tg = TGT_A;
                        else if (ka[1] && kp == lb) n_tg = TGT_B;
                        else n_tg = TGT_NONE;
                        n_ph = is_hdr_key ? PH_HDR_COLON : PH_TOP_COLON;
                    end else begin
                        if (kp >= la || na != i_c) n_ka[0] = 1'b0;
                        if (kp >= lb || nb != i_c) n_ka[1] = 1'b0;
                        if (kp < 5'd31) n_kp = kp + 5'd1;
                    end
                end
                PH_TOP_COLON, PH_HDR_COLON: begin
                    if (i_c == ":") n_ph = (ph == PH_TOP_COLON) ? PH_TOP_VALUE : PH_HDR_VALUE;
                    else if (i_c != " ") begin n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0}; end
                end
                PH_TOP_VALUE: begin
                    if (i_c == " ") begin
                    end else if (tg == TGT_A) begin
                        if (i_c != "{") begin n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0}; end
                        else n_ph = PH_HDR_MEMBER;
                    end else if (tg == TGT_B) begin
                        n_len = '0; n_ph = PH_BODY; o_res = '{1'b1, K_PAY_CLR, 8'd0};
                    end else begin
                        n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0};
                    end
                end
                PH_BODY: begin
                    if (i_c == "\"") n_ph = PH_TOP_AFTER;
                    else if (len < LenW'(PayloadMax)) begin
                        n_len = len + 1'b1; o_res = '{1'b1, K_PAY, i_c};
                    end
                end
                PH_HDR_MEMBER, PH_HDR_AFTER: begin
                    if (i_c == " ") begin
                    end else if (ph == PH_HDR_AFTER && i_c == ",") begin
                        n_ph = PH_HDR_MEMBER;
                    end else if (i_c == "}") begin
                        n_ph = PH_TOP_AFTER;
                    end else begin
                        n_kp = '0; n_ka = 2'd3; n_ph = PH_HDR_KEY;
                    end
                end
                PH_HDR_VALUE: begin
                    if (i_c != " ") begin
                        n_len = '0;
                        if (tg == TGT_A) begin
                            n_ph = PH_HOST; o_res = '{1'b1, K_ROUTE_CLR, 8'd0};
                        end else if (tg == TGT_B) begin
                            o_a_clear = 1'b1; n_ph = PH_XFF;
                        end else begin
                            n_ph = PH_OTHER;
                        end
                    end
                end
                PH_HOST: begin
                    if (i_c == "\"") n_ph = PH_HDR_AFTER;
                    else if (len < LenW'(ValueMax)) begin
                        n_len = len + 1'b1; o_res = '{1'b1, K_ROUTE, i_c};
                    end
                end
                PH_OTHER, PH_XFF_REST: begin
                    if (i_c == "\"") n_ph = PH_HDR_AFTER;
                end
                PH_XFF: begin
                    if (i_c == "\"") begin
                        o_a_commit = 1'b1; n_ph = PH_HDR_AFTER;
                    end else if (i_c == ",") begin
                        o_a_commit = 1'b1; n_ph = PH_XFF_REST;
                    end else if (len < LenW'(ValueMax)) begin
                        n_len = len + 1'b1; o_a_char = 1'b1;
                    end
                end
                default: begin
                    n_fin = 1'b1; o_res = '{1'b1, K_ERR, 8'd0};
                end
            endcase
        end
        if (!i_take) begin
            o_a_clear = 1'b0; o_a_commit = 1'b0; o_a_char = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_START; r_kp <= '0; r_ka <= 2'd3; r_tg <= TGT_NONE;
            r_len <= '0; r_fin <= 1'b0;
        end else if (i_take) begin
            r_ph <= n_ph; r_kp <= n_kp; r_ka <= n_ka; r_tg <= n_tg;
            r_len <= n_len; r_fin <= n_fin;
        end
    end
endmodule
`default_nettype wire

// ===== src/jmfe_checker.sv =====
// Port-level checks for the JSON message field extractor, bound to the top.
// Depends on jmfe_pkg.
`default_nettype none
module jmfe_checker
    import jmfe_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic [31:0] o_client_address
);
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind <= K_ERR)) else $error("bad kind");
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_ROUTE && o_kind != K_PAY |-> o_data_byte == 8'd0)
        else $error("data on non-byte kind");
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_OK |-> o_client_address == 32'd0)
        else $error("address on non-ok kind");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
        && $stable(o_client_address))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("input stalled with empty output");
endmodule

bind json_message_field_extractor jmfe_checker u_jmfe_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall,
    .o_kind, .o_data_byte, .o_client_address
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for json_message_field_extractor: directed and random
// JSON messages, a byte-level parse predictor, and a scoreboard of whole results.
// Depends on jmfe_pkg and the extractor RTL.
`timescale 1ns / 1ps
module testbench;
    import jmfe_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       som;
    } msg_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] addr;
    } parse_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_msg_byte;
    logic        i_start_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_client_address;

    json_message_field_extractor dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_msg_byte         (i_msg_byte),
        .i_start_of_message (i_start_of_message),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_kind             (o_kind),
        .o_data_byte        (o_data_byte),
        .o_client_address   (o_client_address)
    );

    msg_item_t     pending_bytes[$];
    parse_result_t expected_results[$];
    int            bytes_accepted;
    int            results_checked;
    int            msgs_ok;
    int            msgs_err;
    bit            failed;

    // Parser state mirror
    logic [4:0]  phase;
    logic [4:0]  kpos;
    logic [1:0]  alive;
    logic [1:0]  target;
    logic [9:0]  vlen;
    logic [9:0]  oct_acc;
    logic [1:0]  grp_cnt;
    logic [2:0]  oct_idx;
    logic        dig_stop;
    logic [31:0] addr_reg;
    logic        done;

    // Idle profile rotates every few hundred bytes: none, sender, receiver, both.
    function automatic int idle_mode();
        return (bytes_accepted / 300) % 4;
    endfunction

    function automatic bit sender_idles();
        int m;
        m = idle_mode();
        if (m == 1) return $urandom_range(99) < 67;
        if (m == 3) return $urandom_range(99) < 10;
        return 0;
    endfunction

    function automatic bit receiver_stalls();
        int m;
        m = idle_mode();
        if (m == 2) return $urandom_range(99) < 67;
        if (m == 3) return $urandom_range(99) < 10;
        return 0;
    endfunction

    task automatic clear_parser();
        phase = PH_START; kpos = 0; alive = 2'b11; target = TGT_NONE;
        vlen = 0; oct_acc = 0; grp_cnt = 0; oct_idx = 0; dig_stop = 0;
        addr_reg = 0; done = 0;
    endtask

    task automatic push_result(input logic [2:0] k, input logic [7:0] d,
                               input logic [31:0] a);
        parse_result_t r;
        r.kind = k; r.data = d; r.addr = a;
        expected_results.push_back(r);
    endtask

    task automatic close_message(input logic [2:0] k);
        done = 1;
        push_result(k, 8'd0, (k == K_OK) ? addr_reg : 32'd0);
    endtask

    task automatic match_key_char(input logic [7:0] c, input string a, input string b);
        if (kpos >= a.len() || a[kpos] != c) alive &= 2'b10;
        if (kpos >= b.len() || b[kpos] != c) alive &= 2'b01;
        if (kpos < 31) kpos = kpos + 1;
    endtask

    task automatic match_key_end(input int la, input int lb);
        if (alive[0] && kpos == la) target = TGT_A;
        else if (alive[1] && kpos == lb) target = TGT_B;
        else target = TGT_NONE;
    endtask

    task automatic commit_octet();
        if (oct_idx < 4) begin
            addr_reg |= 32'(oct_acc) << (24 - 8 * oct_idx);
            oct_idx++;
        end
        oct_acc = 0; grp_cnt = 0; dig_stop = 0;
    endtask

    task automatic take_addr_char(input logic [7:0] c);
        if (oct_idx >= 4) return;
        if (c == ".") begin
            commit_octet();
            return;
        end
        if (grp_cnt >= 3) begin
            commit_octet();
            if (oct_idx >= 4) return;
        end
        if (!dig_stop && c >= "0" && c <= "9") oct_acc = oct_acc * 10 + (c - "0");
        else dig_stop = 1;
        grp_cnt++;
    endtask

    task automatic top_member_char(input logic [7:0] c);
        if (c == " ") return;
        if (c == "}") begin
            close_message(K_OK);
            return;
        end
        kpos = 0; alive = 2'b11; phase = PH_TOP_KEY;
    endtask

    task automatic hdr_member_char(input logic [7:0] c);
        if (c == " ") return;
        if (c == "}") begin
            phase = PH_TOP_AFTER;
            return;
        end
        kpos = 0; alive = 2'b11; phase = PH_HDR_KEY;
    endtask

    // Advance the parse by one byte and queue whatever result it yields.
    task automatic parse_byte(input logic [7:0] c, input logic som);
        if (som) clear_parser();
        if (done) return;
        if (c == 8'd0) begin
            close_message(K_ERR);
            return;
        end
        case (phase)
            PH_START: begin
                if (c == "{") phase = PH_TOP_MEMBER;
                else if (c != " ") close_message(K_ERR);
            end
            PH_TOP_MEMBER: top_member_char(c);
            PH_TOP_KEY: begin
                if (c == "\"") begin
                    match_key_end(7, 4);
                    phase = PH_TOP_COLON;
                end else match_key_char(c, "headers", "body");
            end
            PH_TOP_COLON: begin
                if (c == ":") phase = PH_TOP_VALUE;
                else if (c != " ") close_message(K_ERR);
            end
            PH_TOP_VALUE: begin
                if (c == " ") return;
                if (target == TGT_A) begin
                    if (c != "{") close_message(K_ERR);
                    else phase = PH_HDR_MEMBER;
                end else if (target == TGT_B) begin
                    vlen = 0; phase = PH_BODY;
                    push_result(K_PAY_CLR, 8'd0, 32'd0);
                end else close_message(K_ERR);
            end
            PH_BODY: begin
                if (c == "\"") phase = PH_TOP_AFTER;
                else if (vlen < PayloadMax) begin
                    vlen++;
                    push_result(K_PAY, c, 32'd0);
                end
            end
            PH_TOP_AFTER: begin
                phase = PH_TOP_MEMBER;
                if (c != ",") top_member_char(c);
            end
            PH_HDR_MEMBER: hdr_member_char(c);
            PH_HDR_KEY: begin
                if (c == "\"") begin
                    match_key_end(4, 15);
                    phase = PH_HDR_COLON;
                end else match_key_char(c, "Host", "X-Forwarded-For");
            end
            PH_HDR_COLON: begin
                if (c == ":") phase = PH_HDR_VALUE;
                else if (c != " ") close_message(K_ERR);
            end
            PH_HDR_VALUE: begin
                if (c == " ") return;
                vlen = 0;
                if (target == TGT_A) begin
                    phase = PH_HOST;
                    push_result(K_ROUTE_CLR, 8'd0, 32'd0);
                end else if (target == TGT_B) begin
                    addr_reg = 0; oct_idx = 0; oct_acc = 0; grp_cnt = 0; dig_stop = 0;
                    phase = PH_XFF;
                end else phase = PH_OTHER;
            end
            PH_HOST: begin
                if (c == "\"") phase = PH_HDR_AFTER;
                else if (vlen < ValueMax) begin
                    vlen++;
                    push_result(K_ROUTE, c, 32'd0);
                end
            end
            PH_OTHER: if (c == "\"") phase = PH_HDR_AFTER;
            PH_XFF: begin
                if (c == "\"") begin
                    commit_octet();
                    phase = PH_HDR_AFTER;
                end else if (c == ",") begin
                    commit_octet();
                    phase = PH_XFF_REST;
                end else if (vlen < ValueMax) begin
                    vlen++;
                    take_addr_char(c);
                end
            end
            PH_XFF_REST: if (c == "\"") phase = PH_HDR_AFTER;
            PH_HDR_AFTER: begin
                if (c == " ") return;
                phase = PH_HDR_MEMBER;
                if (c != ",") hdr_member_char(c);
            end
            default: close_message(K_ERR);
        endcase
    endtask

    // ---------------- stimulus helpers ----------------
    bit next_som;

    task automatic push_byte(input logic [7:0] b);
        msg_item_t it;
        it.b = b; it.som = next_som;
        next_som = 0;
        pending_bytes.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Printable character other than quote; occasionally any other nonzero byte.
    function automatic logic [7:0] content_char();
        logic [7:0] c;
        if ($urandom_range(15) == 0) c = $urandom_range(1, 255);
        else c = $urandom_range(32, 126);
        if (c == "\"") c = "a";
        return c;
    endfunction

    task automatic push_content(input int n);
        for (int i = 0; i < n; i++) push_byte(content_char());
    endtask

    task automatic push_address();
        int groups;
        groups = $urandom_range(1, 5);
        for (int g = 0; g < groups; g++) begin
            case ($urandom_range(5))
                0: push_content($urandom_range(0, 4));
                1: push_text($sformatf("%0d", $urandom_range(255, 999)));
                default: push_text($sformatf("%0d", $urandom_range(0, 255)));
            endcase
            if (g != groups - 1) push_byte($urandom_range(7) == 0 ? "x" : ".");
        end
        if ($urandom_range(2) == 0) begin
            push_text(", ");
            push_text($sformatf("%0d.%0d.0.1", $urandom_range(255), $urandom_range(255)));
        end
    endtask

    task automatic push_spaces();
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) push_byte(" ");
    endtask

    task automatic push_header_member();
        case ($urandom_range(5))
            0, 1: begin
                push_text("\"Host\"");
                push_spaces();
                push_text(":");
                push_spaces();
                push_text("\"");
                push_content($urandom_range(15) == 0 ? $urandom_range(60, 80)
                                                      : $urandom_range(0, 12));
                push_text("\"");
            end
            2, 3: begin
                push_text("\"X-Forwarded-For\":\"");
                push_address();
                push_text("\"");
            end
            4: begin
                push_text("\"X-Forwarded-Fo\":\"");
                push_content($urandom_range(0, 6));
                push_text("\"");
            end
            default: begin
                push_text("\"");
                push_content($urandom_range(0, 35));
                push_text("\":\"");
                push_content($urandom_range(0, 6));
                push_text("\"");
            end
        endcase
    endtask

    task automatic push_message(input int body_len);
        int nmem;
        next_som = 1;
        push_spaces();
        push_text("{");
        nmem = $urandom_range(1, 3);
        for (int m = 0; m < nmem; m++) begin
            if (m != 0) push_text(",");
            push_spaces();
            if ($urandom_range(1) == 0) begin
                int nh;
                push_text("\"headers\":");
                push_spaces();
                push_text("{");
                nh = $urandom_range(0, 4);
                for (int h = 0; h < nh; h++) begin
                    if (h != 0) begin
                        push_spaces();
                        push_text(",");
                    end
                    push_spaces();
                    push_header_member();
                end
                push_spaces();
                push_text("}");
            end else begin
                push_text("\"body\":\"");
                push_content(body_len >= 0 ? body_len : $urandom_range(0, 20));
                push_text("\"");
            end
        end
        push_spaces();
        push_text("}");
        // Trailing bytes after completion are ignored until the next start.
        if ($urandom_range(3) == 0) push_content($urandom_range(1, 3));
    endtask

    // Corrupt a message: cut it short, inject a bad or zero byte, or append random noise.
    task automatic push_broken_message();
        int cut;
        int base;
        base = pending_bytes.size();
        push_message(-1);
        cut = $urandom_range(base + 1, pending_bytes.size() - 1);
        case ($urandom_range(3))
            0: pending_bytes[cut].b = 8'd0;
            1: pending_bytes[cut].b = $urandom_range(0, 255);
            2: begin
                while (pending_bytes.size() > cut) void'(pending_bytes.pop_back());
            end
            default: begin
                next_som = ($urandom_range(1) == 0);
                repeat ($urandom_range(1, 10)) push_byte($urandom_range(0, 255));
            end
        endcase
    endtask

    // ---------------- clock, reset, limit ----------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        msg_item_t it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_msg_byte <= 8'd0;
            i_start_of_message <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_msg_byte, i_start_of_message);
                bytes_accepted++;
            end
            // Hold a stalled transaction; otherwise load the next byte or idle.
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() > 0 && !sender_idles()) begin
                    it = pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_msg_byte <= it.b;
                    i_start_of_message <= it.som;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        parse_result_t e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d data=%h addr=%h",
                             $time, o_kind, o_data_byte, o_client_address);
                    failed = 1;
                end else begin
                    e = expected_results.pop_front();
                    if (o_kind !== e.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, e.kind, o_kind);
                        failed = 1;
                    end
                    if (o_data_byte !== e.data) begin
                        $display("%0t: data_byte expected %h actual %h",
                                 $time, e.data, o_data_byte);
                        failed = 1;
                    end
                    if (o_client_address !== e.addr) begin
                        $display("%0t: client_address expected %h actual %h",
                                 $time, e.addr, o_client_address);
                        failed = 1;
                    end
                    if (e.kind == K_OK) msgs_ok++;
                    if (e.kind == K_ERR) msgs_err++;
                end
                results_checked++;
            end
            i_stall <= receiver_stalls();
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int guard;
        failed = 0; bytes_accepted = 0; results_checked = 0; msgs_ok = 0; msgs_err = 0;
        clear_parser();
        i_valid = 0; i_msg_byte = 0; i_start_of_message = 0; i_stall = 0;

        // Directed: empty object, bad opener, zero byte, unknown key,
        // missing colon, all header fields with digit-stop and 3-digit cut.
        next_som = 1; push_text("{}");
        next_som = 1; push_text("x");
        next_som = 1; push_byte(8'd0);
        next_som = 1; push_text("{\"bodyx\":1}");
        next_som = 1; push_text("{\"body\" x");
        next_som = 1;
        push_text("{\"headers\":{\"Host\":\"h\",\"X-Forwarded-For\":\"255.9a.1234,1\"},");
        push_text("\"body\":\"\\xff\"}");
        pending_bytes[pending_bytes.size() - 3].b = 8'hff;

        // Random: mostly well-formed, some broken, one whose body members, if any, run past the cap.
        for (int n = 0; pending_bytes.size() < 1800; n++) begin
            if (n == 7) push_message($urandom_range(1024, 1030));
            else if ($urandom_range(4) == 0) push_broken_message();
            else push_message(-1);
        end

        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        while (pending_bytes.size() > 0 || i_valid) @(posedge i_clk);
        guard = 0;
        while (expected_results.size() > 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);

        if (expected_results.size() > 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            failed = 1;
        end
        $display("Covered %0d bytes over mixed idle profiles; %0d results checked",
                 bytes_accepted, results_checked);
        $display("Messages completed: %0d ok, %0d with error", msgs_ok, msgs_err);
        if (!failed) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
